### hw/rtl/dpsa_pkg.sv
// Shared types and constants for the dual pair sample arithmetic block.
`default_nettype none
package dpsa_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int CHAN_W     = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int EPS_W      = 17;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 264;
   localparam int NUM_VALUES = 8;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_DIV_ZERO_HOLD = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_ABS_INT_FRAC  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_CLIP_LOW      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_CLIP_HIGH     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_DIV_EPSILON   = 3'd4;

   // Result groups
   localparam logic GROUP_AB = 1'b0;
   localparam logic GROUP_CD = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIVIDE,
      ST_SEND_AB,
      ST_SEND_CD
   } state_type;

   typedef struct packed {
      logic load;     // capture request, read held quotients
      logic start;    // launch dividers, register first stage values
      logic store;    // finish quotients, write back held values
      logic sel_cd;   // present the CD result
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

   // Saturate a wide signed value to 32 bits
   function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [64:0] x);
      logic signed [64:0] hi;
      logic signed [64:0] lo;
      hi = 65'sh0_7FFF_FFFF;
      lo = -65'sh0_8000_0000;
      if (x > hi) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (x < lo) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = x[SAMPLE_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

### hw/rtl/dpsa_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module dpsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    we,
   input  wire logic [AW-1:0]           waddr,
   input  wire logic [WIDTH-1:0]        wdata,
   input  wire logic                    re,
   input  wire logic [AW-1:0]           raddr,
   output      logic [WIDTH-1:0]        rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

### hw/rtl/dpsa_div.sv
// Radix-2 restoring divider for signed fixed-point quotients, one bit per cycle.
`default_nettype none
module dpsa_div #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [dpsa_pkg::SAMPLE_W-1:0]  num,
   input  wire logic signed [dpsa_pkg::SAMPLE_W-1:0]  den,
   output      logic                                  done,
   output      logic signed [dpsa_pkg::SAMPLE_W-1:0]  quo
);
   localparam int SW = dpsa_pkg::SAMPLE_W;
   localparam int DW = SW + FRAC_BITS;
   localparam int CW = $clog2(DW + 1);
   localparam logic [DW-1:0] POS_LIM = DW'(33'h0_7FFF_FFFF);
   localparam logic [DW-1:0] NEG_LIM = DW'(33'h0_8000_0000);

   logic [DW-1:0]    dvd_ff, dvd_in;
   logic [SW-1:0]    rem_ff, rem_in;
   logic [SW-1:0]    dmag_ff, dmag_in;
   logic             neg_ff, neg_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [SW:0]      num_abs, den_abs;
   logic [SW:0]      trial, diff;
   logic             ge;

   // Magnitudes of the operands
   always_comb begin
      num_abs = num[SW-1] ? -{num[SW-1], num} : {num[SW-1], num};
      den_abs = den[SW-1] ? -{den[SW-1], den} : {den[SW-1], den};
   end

   // One quotient bit per step
   always_comb begin
      trial = {rem_ff, dvd_ff[DW-1]};
      diff  = trial - {1'b0, dmag_ff};
      ge    = (trial >= {1'b0, dmag_ff});
   end

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = {num_abs[SW-1:0], {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         dmag_in = den_abs[SW-1:0];
         neg_in  = num[SW-1] ^ den[SW-1];
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DW-2:0], ge};
         rem_in = ge ? diff[SW-1:0] : trial[SW-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   // Apply sign and saturate the magnitude
   always_comb begin
      if (neg_ff) begin
         quo = (dvd_ff > NEG_LIM) ? 32'sh8000_0000 : -$signed(dvd_ff[SW-1:0]);
      end else begin
         quo = (dvd_ff > POS_LIM) ? 32'sh7FFF_FFFF : $signed(dvd_ff[SW-1:0]);
      end
   end

   assign done = done_ff;
endmodule
`default_nettype wire

### hw/rtl/dpsa_datapath.sv
// Datapath: registers, comparisons, arithmetic, dividers, held quotients and clipping.
`default_nettype none
module dpsa_datapath #(
   parameter int CHANNELS  = 16,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire dpsa_pkg::cmd_type                       cmd,
   output      dpsa_pkg::status_type                    status,
   input  wire logic [dpsa_pkg::REQ_DATA_W-1:0]         req_tdata,
   input  wire logic [1:0]                              req_tuser,
   input  wire logic                                    csr_we,
   input  wire logic [dpsa_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  wire logic [dpsa_pkg::CSR_DATA_W-1:0]         csr_wdata,
   output      logic [dpsa_pkg::RSP_DATA_W-1:0]         rsp_tdata
);
   localparam int SW = dpsa_pkg::SAMPLE_W;
   localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int NCH = 2 ** dpsa_pkg::CHAN_W;
   localparam logic [SW:0] INT_MASK = ~((33'd1 << FRAC_BITS) - 33'd1);

   // Configuration registers
   logic                              hold_ff;
   logic                              absif_ff;
   logic signed [SW-1:0]              clip_lo_ff;
   logic signed [SW-1:0]              clip_hi_ff;
   logic [dpsa_pkg::EPS_W-1:0]        eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff    <= 1'b1;
         absif_ff   <= 1'b0;
         clip_lo_ff <= -32'sd655360;
         clip_hi_ff <= 32'sd655360;
         eps_ff     <= 17'd1;
      end else if (csr_we) begin
         unique case (csr_addr)
            dpsa_pkg::REG_DIV_ZERO_HOLD: hold_ff    <= csr_wdata[0];
            dpsa_pkg::REG_ABS_INT_FRAC:  absif_ff   <= csr_wdata[0];
            dpsa_pkg::REG_CLIP_LOW:      clip_lo_ff <= csr_wdata;
            dpsa_pkg::REG_CLIP_HIGH:     clip_hi_ff <= csr_wdata;
            dpsa_pkg::REG_DIV_EPSILON:   eps_ff     <= csr_wdata[dpsa_pkg::EPS_W-1:0];
            default: ;
         endcase
      end
   end

   // Channel to state index map
   logic [IW-1:0] idx_map [NCH];
   for (genvar i = 0; i < NCH; i++) begin : g_idx
      assign idx_map[i] = IW'(i % CHANNELS);
   end

   logic [dpsa_pkg::CHAN_W-1:0] req_ch;
   logic [IW-1:0]               req_idx;
   assign req_ch  = req_tdata[3:0];
   assign req_idx = idx_map[req_ch];

   // Capture the request
   logic [dpsa_pkg::CHAN_W-1:0] ch_ff;
   logic [IW-1:0]               idx_ff;
   logic signed [SW-1:0]        a_ff, b_ff, c_ff, d_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff  <= req_ch;
         idx_ff <= req_idx;
         a_ff   <= req_tdata[35:4];
         b_ff   <= req_tdata[67:36];
         c_ff   <= req_tuser[0] ? req_tdata[99:68]  : req_tdata[35:4];
         d_ff   <= req_tuser[1] ? req_tdata[131:100] : req_tdata[67:36];
      end
   end

   // Held quotients with per-channel valid bits
   logic [CHANNELS-1:0] valid_ff;
   logic [2*SW-1:0]     ram_rdata;
   logic signed [SW-1:0] qcd_ff, qdc_ff;
   logic signed [SW-1:0] qcd_in_w, qdc_in_w;

   dpsa_ram #(.WIDTH(2 * SW), .DEPTH(CHANNELS)) u_held (
      .clock (clock),
      .we    (cmd.store),
      .waddr (idx_ff),
      .wdata ({qdc_in_w, qcd_in_w}),
      .re    (cmd.load),
      .raddr (req_idx),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.store) begin
         valid_ff[idx_ff] <= 1'b1;
      end
   end

   // First stage values
   logic signed [SW:0]   a33, b33, c33, d33;
   logic [SW:0]          abs_a, abs_b, abs_c, abs_d;
   logic signed [SW:0]   ab_diff, ab_sum, ab_adiff;
   logic [SW:0]          c_trunc;
   logic signed [SW:0]   ip33, fp33, ip_abs, fp_abs;

   always_comb begin
      a33 = {a_ff[SW-1], a_ff};
      b33 = {b_ff[SW-1], b_ff};
      c33 = {c_ff[SW-1], c_ff};
      d33 = {d_ff[SW-1], d_ff};
      abs_a = a_ff[SW-1] ? -a33 : a33;
      abs_b = b_ff[SW-1] ? -b33 : b33;
      abs_c = c_ff[SW-1] ? -c33 : c33;
      abs_d = d_ff[SW-1] ? -d33 : d33;
      ab_diff  = a33 - b33;
      ab_adiff = ab_diff[SW] ? -ab_diff : ab_diff;
      ab_sum   = a33 + b33;
      c_trunc  = abs_c & INT_MASK;
      ip33     = c_ff[SW-1] ? -$signed(c_trunc) : $signed(c_trunc);
      fp33     = c33 - ip33;
      ip_abs   = ip33[SW] ? -ip33 : ip33;
      fp_abs   = fp33[SW] ? -fp33 : fp33;
   end

   logic signed [SW-1:0] ab_ff [6];
   logic signed [SW-1:0] ip_ff, fp_ff, sum_ff, cmd_ff, dmc_ff;
   logic signed [2*SW-1:0] prod_ff;
   logic signed [SW-1:0] held_cd_ff, held_dc_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         ab_ff[0] <= (a_ff < b_ff) ? a_ff : b_ff;
         ab_ff[1] <= (a_ff > b_ff) ? a_ff : b_ff;
         ab_ff[2] <= (abs_a < abs_b) ? a_ff : b_ff;
         ab_ff[3] <= (abs_a > abs_b) ? a_ff : b_ff;
         ab_ff[4] <= dpsa_pkg::sat32(65'(ab_adiff));
         ab_ff[5] <= ab_sum[SW:1];
         ip_ff  <= absif_ff ? dpsa_pkg::sat32(65'(ip_abs)) : ip33[SW-1:0];
         fp_ff  <= absif_ff ? fp_abs[SW-1:0] : fp33[SW-1:0];
         sum_ff <= dpsa_pkg::sat32(65'(c33 + d33));
         cmd_ff <= dpsa_pkg::sat32(65'(c33 - d33));
         dmc_ff <= dpsa_pkg::sat32(65'(d33 - c33));
         prod_ff <= c_ff * d_ff;
         held_cd_ff <= valid_ff[idx_ff] ? ram_rdata[SW-1:0]    : '0;
         held_dc_ff <= valid_ff[idx_ff] ? ram_rdata[2*SW-1:SW] : '0;
      end
   end

   // Dividers for C/D and D/C
   logic                 done_cd, done_dc;
   logic signed [SW-1:0] quo_cd, quo_dc;

   dpsa_div #(.FRAC_BITS(FRAC_BITS)) u_div_cd (
      .clock (clock), .reset (reset), .start (cmd.start),
      .num (c_ff), .den (d_ff), .done (done_cd), .quo (quo_cd)
   );

   dpsa_div #(.FRAC_BITS(FRAC_BITS)) u_div_dc (
      .clock (clock), .reset (reset), .start (cmd.start),
      .num (d_ff), .den (c_ff), .done (done_dc), .quo (quo_dc)
   );

   assign status.div_done = done_cd & done_dc;

   // Replace the quotient on a tiny divisor
   logic tiny_d, tiny_c;
   logic signed [2*SW-1:0] prod_sh;
   logic signed [SW-1:0] mul_ff;

   always_comb begin
      tiny_d = (abs_d == '0) || (abs_d < {16'd0, eps_ff});
      tiny_c = (abs_c == '0) || (abs_c < {16'd0, eps_ff});
      qcd_in_w = tiny_d ? (hold_ff ? held_cd_ff : '0) : quo_cd;
      qdc_in_w = tiny_c ? (hold_ff ? held_dc_ff : '0) : quo_dc;
      prod_sh  = prod_ff >>> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         qcd_ff <= qcd_in_w;
         qdc_ff <= qdc_in_w;
         mul_ff <= dpsa_pkg::sat32(65'(prod_sh));
      end
   end

   // Select the result group and clip every value
   logic signed [SW-1:0] raw [dpsa_pkg::NUM_VALUES];
   logic signed [SW-1:0] clipped [dpsa_pkg::NUM_VALUES];

   always_comb begin
      if (cmd.sel_cd) begin
         raw[0] = ip_ff;  raw[1] = fp_ff;  raw[2] = sum_ff; raw[3] = mul_ff;
         raw[4] = cmd_ff; raw[5] = dmc_ff; raw[6] = qcd_ff; raw[7] = qdc_ff;
      end else begin
         raw[0] = ab_ff[0]; raw[1] = ab_ff[1]; raw[2] = ab_ff[2]; raw[3] = ab_ff[3];
         raw[4] = ab_ff[4]; raw[5] = ab_ff[5]; raw[6] = '0;       raw[7] = '0;
      end
      for (int i = 0; i < dpsa_pkg::NUM_VALUES; i++) begin
         clipped[i] = (raw[i] < clip_lo_ff) ? clip_lo_ff : raw[i];
         if (clipped[i] > clip_hi_ff) begin
            clipped[i] = clip_hi_ff;
         end
      end
      // Keep the two spare AB slots at zero, outside the clip limits
      if (!cmd.sel_cd) begin
         clipped[6] = '0;
         clipped[7] = '0;
      end
   end

   assign rsp_tdata = {4'd0, clipped[7], clipped[6], clipped[5], clipped[4],
                       clipped[3], clipped[2], clipped[1], clipped[0], ch_ff};
endmodule
`default_nettype wire

### hw/rtl/dpsa_ctrl.sv
// Controller state machine: sequences capture, division and the two results.
`default_nettype none
module dpsa_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic                  rsp_tlast,
   output      logic                  rsp_tuser,
   input  wire dpsa_pkg::status_type  status,
   output      dpsa_pkg::cmd_type     cmd
);
   dpsa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dpsa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dpsa_pkg::ST_IDLE:    if (req_tvalid) state_in = dpsa_pkg::ST_FETCH;
         dpsa_pkg::ST_FETCH:   state_in = dpsa_pkg::ST_DIVIDE;
         dpsa_pkg::ST_DIVIDE:  if (status.div_done) state_in = dpsa_pkg::ST_SEND_AB;
         dpsa_pkg::ST_SEND_AB: if (rsp_tready) state_in = dpsa_pkg::ST_SEND_CD;
         dpsa_pkg::ST_SEND_CD: if (rsp_tready) state_in = dpsa_pkg::ST_IDLE;
         default:              state_in = dpsa_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tlast  = 1'b0;
      rsp_tuser  = dpsa_pkg::GROUP_AB;
      cmd        = '0;
      unique case (state_ff)
         dpsa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         dpsa_pkg::ST_FETCH: begin
            cmd.start = 1'b1;
         end
         dpsa_pkg::ST_DIVIDE: begin
            cmd.store = status.div_done;
         end
         dpsa_pkg::ST_SEND_AB: begin
            rsp_tvalid = 1'b1;
         end
         dpsa_pkg::ST_SEND_CD: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = 1'b1;
            rsp_tuser  = dpsa_pkg::GROUP_CD;
            cmd.sel_cd = 1'b1;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

### hw/rtl/dual_pair_sample_arithmetic.sv
// Top level of the dual pair sample arithmetic block.
// Takes one request at a time and returns two results for it: the AB result
// (min, max, nearer and farther from zero, |A-B|, average), then the CD result
// (integer and fractional part of C, C+D, C*D, C-D, D-C, C/D, D/C), all clipped
// to the configured limits. The AB result is offered once the two bit-serial
// dividers, which run side by side at one quotient bit per cycle over
// 32 + FRAC_BITS bits, are both done; the CD result follows once the AB
// result is taken, and the next request is taken only after the CD result is
// taken. Held quotients live in a CHANNELS-deep RAM whose entries read as zero
// until first written after reset.
`default_nettype none
module dual_pair_sample_arithmetic #(
   parameter int CHANNELS  = 16,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   // channel, sample_a, sample_b, sample_c, sample_d, zero pad
   input  wire logic [dpsa_pkg::REQ_DATA_W-1:0]      req_tdata,
   // c_present, d_present
   input  wire logic [1:0]                           req_tuser,
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // out_channel, value0 .. value7, zero pad
   output      logic [dpsa_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // group
   output      logic                                 rsp_tuser,
   output      logic                                 rsp_tlast,
   input  wire logic                                 csr_we,
   input  wire logic [dpsa_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [dpsa_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   dpsa_pkg::cmd_type    cmd;
   dpsa_pkg::status_type status;

   dpsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   dpsa_datapath #(.CHANNELS(CHANNELS), .FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );
endmodule
`default_nettype wire

### hw/rtl/dpsa_checker.sv
// Port-level checker for the dual pair sample arithmetic block, with its bind.
`default_nettype none
module dpsa_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [dpsa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic                              rsp_tuser,
   input wire logic                              rsp_tlast
);
   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Mark the CD result as last
   a_last_group: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == rsp_tuser)
      else $error("last flag does not match group");

   // Follow an accepted AB result with its CD result
   a_ab_then_cd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("AB result not followed by CD result");

   // Take no request while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted during result delivery");

   // Produce no result and take no request in the cycle after a request
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid && !req_tready)
      else $error("result or request right after request");
endmodule

bind dual_pair_sample_arithmetic dpsa_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
